>>> hw/rtl/pidfd_pkg.sv
// Shared types, codes and saturation helpers for the filtered-derivative PID block.
package pidfd_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int OPND_W = 33;
  localparam int PROD_W = 66;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    FN_UPDATE = 2'd0,
    FN_FREEZE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_RESET  = 2'd3
  } func_t;

  localparam logic [2:0] REG_PROP   = 3'd0;
  localparam logic [2:0] REG_INTEG  = 3'd1;
  localparam logic [2:0] REG_DERIV  = 3'd2;
  localparam logic [2:0] REG_WINDUP = 3'd3;
  localparam logic [2:0] REG_FILTER = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_EMUL,
    ST_IMUL,
    ST_INTEG,
    ST_FMUL,
    ST_FDIV,
    ST_KMUL,
    ST_KDIV,
    ST_FINAL,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? Q_MIN : Q_MAX;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33] != v[32]) || (v[33] != v[31])) r = v[33] ? Q_MIN : Q_MAX;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/pid_with_filtered_derivative.sv
// Top level: PID controller with anti-windup clamp and low-pass filtered derivative.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+--------------------------------------
//   in      | into      | in_valid / in_ready   | func, measured, setpoint, step_time
//   out     | out of    | out_valid / out_ready | drive, integ_value
//   cfg     | into      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One word at a time. Freeze, clear and reset words go from idle straight to the done
// state, which loads the output register. An update word runs the P, e*dt and I
// multiplies and the integrator, then the final sum on the first sample; later it first
// runs the derivative multiply and divide, after a filter multiply and divide when the
// filter is on. Each serial multiply has 33 steps, each serial divide 32 (launch, steps,
// done); the final sum and the load follow. in_ready returns as the register loads.
// Reset clears gains, controller state and out_valid, but not drive or integ_value.
// A stalled out word holds in the output register while the next input word is taken;
// the result of that next word waits in the done state until the register frees up.
module pid_with_filtered_derivative #(
  parameter int FRAC_BITS = pidfd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] measured,
  input  logic signed [31:0] setpoint,
  input  logic [30:0]        step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic signed [31:0] integ_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // tuning registers
  logic signed [31:0] prop_gain, integ_gain, deriv_gain, windup_limit, filter_period;

  // controller state
  logic signed [31:0] integ_acc, integ_before, filtered_err, last_filtered_err;
  logic signed [31:0] last_drive;
  logic               first_pending;

  // per-word working registers
  logic signed [31:0] err;
  logic [30:0]        dt;
  logic signed [31:0] p_term, e_dt, ig;
  logic signed [33:0] cmd;

  pidfd_pkg::state_t state, state_next, after_op;
  logic op_live, op_live_next;
  logic is_mul, is_div;

  logic                                mul_start, mul_done, mul_neg;
  logic signed [pidfd_pkg::OPND_W-1:0] mul_a, mul_b;
  logic [pidfd_pkg::PROD_W-1:0]        mul_mag;
  logic signed [31:0]                  mul_q;

  logic               div_start, div_done;
  logic [31:0]        div_den;
  logic signed [31:0] div_q;

  logic               accept, load_out;
  logic signed [31:0] integ_sum, integ_new;

  assign in_ready  = (state == pidfd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == pidfd_pkg::ST_DONE) && (!out_valid || out_ready);

  pidfd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .neg   (mul_neg),
    .mag   (mul_mag),
    .q     (mul_q)
  );

  pidfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (mul_neg),
    .mag   (mul_mag[63:0]),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // steer operands into the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      pidfd_pkg::ST_PMUL: begin
        mul_a = {err[31], err};
        mul_b = {prop_gain[31], prop_gain};
      end
      pidfd_pkg::ST_EMUL: begin
        mul_a = {err[31], err};
        mul_b = {2'b00, dt};
      end
      pidfd_pkg::ST_IMUL: begin
        mul_a = {integ_gain[31], integ_gain};
        mul_b = {e_dt[31], e_dt};
      end
      pidfd_pkg::ST_FMUL: begin
        mul_a = {err[31], err} - {filtered_err[31], filtered_err};
        mul_b = {2'b00, dt};
      end
      pidfd_pkg::ST_KMUL: begin
        mul_a = {filtered_err[31], filtered_err}
              - {last_filtered_err[31], last_filtered_err};
        mul_b = {deriv_gain[31], deriv_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // filter divides by tau + dt, the derivative by dt alone
  assign div_den = (state == pidfd_pkg::ST_FDIV)
                 ? ({1'b0, filter_period[30:0]} + {1'b0, dt})
                 : {1'b0, dt};

  // integrator: add, saturate, then clamp when the limit is positive
  assign integ_sum = pidfd_pkg::sat33({integ_acc[31], integ_acc} + {ig[31], ig});
  always_comb begin
    integ_new = integ_sum;
    if (windup_limit > 0) begin
      if (integ_sum > windup_limit) integ_new = windup_limit;
      else if (integ_sum < -windup_limit) integ_new = -windup_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pidfd_pkg::ST_IDLE;
      op_live <= 1'b0;
    end else begin
      state   <= state_next;
      op_live <= op_live_next;
    end
  end

  always_comb begin
    state_next   = state;
    op_live_next = op_live;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    is_mul       = 1'b0;
    is_div       = 1'b0;
    after_op     = state;
    unique case (state)
      pidfd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (pidfd_pkg::func_t'(func) == pidfd_pkg::FN_UPDATE)
                     ? pidfd_pkg::ST_PMUL : pidfd_pkg::ST_DONE;
        end
      end
      pidfd_pkg::ST_PMUL: begin
        is_mul   = 1'b1;
        after_op = pidfd_pkg::ST_EMUL;
      end
      pidfd_pkg::ST_EMUL: begin
        is_mul   = 1'b1;
        after_op = pidfd_pkg::ST_IMUL;
      end
      pidfd_pkg::ST_IMUL: begin
        is_mul   = 1'b1;
        after_op = pidfd_pkg::ST_INTEG;
      end
      pidfd_pkg::ST_INTEG: begin
        if (first_pending) state_next = pidfd_pkg::ST_FINAL;
        else if (filter_period > 0) state_next = pidfd_pkg::ST_FMUL;
        else state_next = pidfd_pkg::ST_KMUL;
      end
      pidfd_pkg::ST_FMUL: begin
        is_mul   = 1'b1;
        after_op = pidfd_pkg::ST_FDIV;
      end
      pidfd_pkg::ST_FDIV: begin
        is_div   = 1'b1;
        after_op = pidfd_pkg::ST_KMUL;
      end
      pidfd_pkg::ST_KMUL: begin
        is_mul   = 1'b1;
        after_op = pidfd_pkg::ST_KDIV;
      end
      pidfd_pkg::ST_KDIV: begin
        is_div   = 1'b1;
        after_op = pidfd_pkg::ST_FINAL;
      end
      pidfd_pkg::ST_FINAL: state_next = pidfd_pkg::ST_DONE;
      pidfd_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = pidfd_pkg::ST_IDLE;
      end
      default: state_next = pidfd_pkg::ST_IDLE;
    endcase

    // launch the unit once, then wait for its done pulse
    if (is_mul || is_div) begin
      if (!op_live) begin
        mul_start    = is_mul;
        div_start    = is_div;
        op_live_next = 1'b1;
      end else if ((is_mul && mul_done) || (is_div && div_done)) begin
        op_live_next = 1'b0;
        state_next   = after_op;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain         <= '0;
      integ_gain        <= '0;
      deriv_gain        <= '0;
      windup_limit      <= '0;
      filter_period     <= '0;
      integ_acc         <= '0;
      integ_before      <= '0;
      filtered_err      <= '0;
      last_filtered_err <= '0;
      last_drive        <= '0;
      first_pending     <= 1'b1;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          pidfd_pkg::REG_PROP:   prop_gain     <= cfg_data;
          pidfd_pkg::REG_INTEG:  integ_gain    <= cfg_data;
          pidfd_pkg::REG_DERIV:  deriv_gain    <= cfg_data;
          pidfd_pkg::REG_WINDUP: windup_limit  <= cfg_data;
          pidfd_pkg::REG_FILTER: filter_period <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        unique case (pidfd_pkg::func_t'(func))
          pidfd_pkg::FN_UPDATE: begin
            err <= pidfd_pkg::sat33({setpoint[31], setpoint} - {measured[31], measured});
            dt  <= (step_time == '0) ? 31'd1 : step_time;
          end
          pidfd_pkg::FN_FREEZE: integ_acc <= integ_before;
          pidfd_pkg::FN_CLEAR:  integ_acc <= '0;
          pidfd_pkg::FN_RESET: begin
            integ_acc         <= '0;
            integ_before      <= '0;
            filtered_err      <= '0;
            last_filtered_err <= '0;
            last_drive        <= '0;
            first_pending     <= 1'b1;
          end
          default: ;
        endcase
      end

      if (mul_done && op_live) begin
        if (state == pidfd_pkg::ST_PMUL) p_term <= mul_q;
        if (state == pidfd_pkg::ST_EMUL) e_dt   <= mul_q;
        if (state == pidfd_pkg::ST_IMUL) ig     <= mul_q;
      end

      if (state == pidfd_pkg::ST_INTEG) begin
        integ_before <= integ_acc;
        integ_acc    <= integ_new;
        cmd          <= {{2{p_term[31]}}, p_term} + {{2{integ_new[31]}}, integ_new};
        // unfiltered: derivative sees the raw error
        if (!first_pending && !(filter_period > 0)) filtered_err <= err;
      end

      if (div_done && op_live) begin
        if (state == pidfd_pkg::ST_FDIV) begin
          filtered_err <= pidfd_pkg::sat33({filtered_err[31], filtered_err}
                                           + {div_q[31], div_q});
        end
        if (state == pidfd_pkg::ST_KDIV) cmd <= cmd + {{2{div_q[31]}}, div_q};
      end

      if (state == pidfd_pkg::ST_FINAL) begin
        last_filtered_err <= filtered_err;
        first_pending     <= 1'b0;
        last_drive        <= pidfd_pkg::sat34(cmd);
      end

      // load a new word, or drop the one just taken
      if (load_out) begin
        out_valid   <= 1'b1;
        drive       <= last_drive;
        integ_value <= integ_acc;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/pidfd_mul.sv
// Bit-serial sign-magnitude multiplier with rounded, saturated fixed-point result.
module pidfd_mul #(
  parameter int FRAC_BITS = pidfd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pidfd_pkg::OPND_W-1:0]  a,
  input  logic signed [pidfd_pkg::OPND_W-1:0]  b,
  output logic                                 done,
  output logic                                 neg,
  output logic        [pidfd_pkg::PROD_W-1:0]  mag,
  output logic signed [31:0]                   q
);

  logic [pidfd_pkg::OPND_W-1:0] a_mag;
  logic [pidfd_pkg::PROD_W-1:0] prod;
  logic [5:0]                   cnt;
  logic                         busy;
  logic [pidfd_pkg::OPND_W:0]   sum;
  logic [pidfd_pkg::PROD_W:0]   rnd;
  logic [pidfd_pkg::PROD_W:0]   qm;

  // add the multiplicand when the low bit of the multiplier is set
  assign sum = {1'b0, prod[pidfd_pkg::PROD_W-1:pidfd_pkg::OPND_W]}
             + (prod[0] ? {1'b0, a_mag} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        neg   <= a[pidfd_pkg::OPND_W-1] ^ b[pidfd_pkg::OPND_W-1];
        a_mag <= a[pidfd_pkg::OPND_W-1] ? (~a + 1'b1) : a;
        prod  <= {{pidfd_pkg::OPND_W{1'b0}},
                  (b[pidfd_pkg::OPND_W-1] ? (~b + 1'b1) : b)};
      end else if (busy) begin
        prod <= {sum, prod[pidfd_pkg::OPND_W-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == 6'(pidfd_pkg::OPND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign mag = prod;

  // round half away from zero on the magnitude, then saturate
  assign rnd = {1'b0, prod} + ((pidfd_pkg::PROD_W+1)'(1) << (FRAC_BITS - 1));
  assign qm  = rnd >> FRAC_BITS;

  always_comb begin
    if (neg) begin
      q = (qm > (pidfd_pkg::PROD_W+1)'(33'h0_8000_0000)) ? pidfd_pkg::Q_MIN
                                                          : -qm[31:0];
    end else begin
      q = (qm > (pidfd_pkg::PROD_W+1)'(32'h7fff_ffff)) ? pidfd_pkg::Q_MAX
                                                        : qm[31:0];
    end
  end

endmodule

>>> hw/rtl/pidfd_div.sv
// Bit-serial restoring divider, rounded to nearest and saturated to 32 bits.
module pidfd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               neg,
  input  logic        [63:0] mag,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [31:0] q
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic        over;
  logic        sign;
  logic [64:0] num;
  logic [33:0] trial;

  // bias by half the divisor for round to nearest
  assign num   = {1'b0, mag} + {34'b0, den[31:1]};
  assign trial = {1'b0, rem, quo[31]} - {2'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sign <= neg;
        dsr  <= den;
        over <= num[64:32] >= {1'b0, den};
        rem  <= num[63:32];
        quo  <= num[31:0];
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (sign) begin
      q = (over || (quo > 32'h8000_0000)) ? pidfd_pkg::Q_MIN : -quo;
    end else begin
      q = (over || quo[31]) ? pidfd_pkg::Q_MAX : quo;
    end
  end

endmodule

>>> hw/rtl/pidfd_chk.sv
// Port-level checks for the PID block, bound to the top level.
module pidfd_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] drive,
  input logic signed [31:0] integ_value
);

  // a stalled out word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(integ_value))
    else $error("out word changed while stalled");

  // a taken word leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  // a new result only appears after work was under way
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word in flight");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out word present after reset");

endmodule

bind pid_with_filtered_derivative pidfd_chk u_pidfd_chk (.*);
